[hw/rtl/lhb_pkg.sv]
// Shared constants, types and the sequencer control store of the length histogram binner.
`timescale 1ns / 1ps

package lhb_pkg;

    localparam int NUM_BINS       = 256;
    localparam int BIN_W          = $clog2(NUM_BINS);
    localparam int COORD_W        = 24;
    localparam int LEN_W          = COORD_W + 1;
    localparam int CNT_W          = 32;
    localparam int BS_W           = 16;
    localparam int RBIN_W         = 8;
    localparam int TOUCH_W        = 8;
    localparam int DIV_STEPS      = LEN_W;
    localparam int DCNT_W         = $clog2(DIV_STEPS + 1);
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 40;

    localparam logic [BS_W-1:0]  BIN_SIZE_RESET = 16'd100;
    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_SETUP  = 3'd1,
        STEP_DIV    = 3'd2,
        STEP_ADDR   = 3'd3,
        STEP_FETCH  = 3'd4,
        STEP_UPDATE = 3'd5,
        STEP_DONE   = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_IN    = 3'd2,
        COND_IS_READ  = 3'd3,
        COND_DIV_BUSY = 3'd4,
        COND_OUT_BUSY = 3'd5
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t target;
        logic  take_in;
        logic  div_init;
        logic  div_step;
        logic  set_addr;
        logic  mem_read;
        logic  update;
    } ctl_word_t;

    function automatic ctl_word_t rom_word(input step_t pc);
        ctl_word_t w;
        w = '{cond: COND_ALWAYS, target: STEP_IDLE, default: 1'b0};
        unique case (pc)
            STEP_IDLE:
            begin
                w.cond    = COND_NO_IN;
                w.target  = STEP_IDLE;
                w.take_in = 1'b1;
            end
            STEP_SETUP:
            begin
                w.cond     = COND_IS_READ;
                w.target   = STEP_ADDR;
                w.div_init = 1'b1;
            end
            STEP_DIV:
            begin
                w.cond     = COND_DIV_BUSY;
                w.target   = STEP_DIV;
                w.div_step = 1'b1;
            end
            STEP_ADDR:
            begin
                w.cond     = COND_NEVER;
                w.set_addr = 1'b1;
            end
            STEP_FETCH:
            begin
                w.cond     = COND_NEVER;
                w.mem_read = 1'b1;
            end
            STEP_UPDATE:
            begin
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_UPDATE;
                w.update = 1'b1;
            end
            STEP_DONE:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/length_histogram_binner_unit.sv]
// Top level of the length histogram binner: microcoded sequencer, serial divider, bin store.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream (s_*): one transaction per command. s_tuser is the command
//   (add a length or read a bin); s_tdata carries the coordinates and the bin
//   to read. Master stream (m_*): exactly one result per command, in order.
//   cfg_wr_en / cfg_wr_data write the bin size; write it only while idle.
// Sequence:
//   An add passes through setup, the restoring divider (one quotient bit
//   per cycle), address, memory read and update, where its result is
//   loaded. A read skips the divider and goes from setup to address. After
//   the update the sequencer passes a done step back to idle; only there is
//   the next command accepted, once the sequencer has finished the last one.
// Reset:
//   All bin counts read as zero (per-bin valid flags are cleared), bin size
//   returns to 100, no result is pending.
// Stall:
//   The result is held in an output register; a new command is accepted while
//   it waits, and the sequencer holds in its update step until the register
//   frees up.

module length_histogram_binner_unit
    import lhb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [BS_W-1:0]       cfg_wr_data,    // bin_size
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,        // first_coord, last_coord, read_bin
    input  logic                  s_tuser,        // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,        // bin_touched, bin_count
    output logic                  m_tuser         // negative_length
);

    step_t     pc_reg, pc_next;
    ctl_word_t ctl;
    logic      cond_hit;

    logic [BS_W-1:0]    bin_size_reg;
    logic               cmd_reg;
    logic [COORD_W-1:0] first_reg, last_reg;
    logic [RBIN_W-1:0]  rbin_reg;

    logic               neg_reg, zero_reg;
    logic [LEN_W-1:0]   quo_reg;
    logic [BS_W-1:0]    rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;

    logic [BIN_W-1:0]   addr_reg;
    logic [TOUCH_W-1:0] touched_reg;
    logic               oor_reg;

    logic [CNT_W-1:0]   mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    logic [CNT_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;

    logic               out_valid_reg;
    logic [TOUCH_W-1:0] out_bin_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_neg_reg;

    logic               in_accept;
    logic [LEN_W-1:0]   last_p1;
    logic [LEN_W-1:0]   length;
    logic [BS_W:0]      rem_sh;
    logic               qbit;
    logic [LEN_W:0]     q_p1;
    logic [BIN_W-1:0]   bin_calc;
    logic [31:0]        bin_ext, rbin_ext;
    logic [CNT_W-1:0]   cur_count, inc_count;
    logic               do_update, mem_we;

    assign ctl       = rom_word(pc_reg);
    assign s_tready  = ctl.take_in;
    assign in_accept = s_tvalid & s_tready;

    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NO_IN:    cond_hit = !s_tvalid;
            COND_IS_READ:  cond_hit = (cmd_reg == CMD_READ);
            COND_DIV_BUSY: cond_hit = (dcnt_reg != DCNT_W'(1));
            COND_OUT_BUSY: cond_hit = out_valid_reg & !m_tready;
            default:       cond_hit = 1'b1;
        endcase
        pc_next = cond_hit ? ctl.target : step_t'(pc_reg + 3'd1);
    end

    assign last_p1  = {1'b0, last_reg} + LEN_W'(1);
    assign length   = last_p1 - {1'b0, first_reg};
    assign rem_sh   = {rem_reg, quo_reg[LEN_W-1]};
    assign qbit     = rem_sh >= {1'b0, bin_size_reg};
    assign q_p1     = {1'b0, quo_reg} + (LEN_W + 1)'(1);
    assign rbin_ext = 32'(rbin_reg);

    always_comb
    begin
        if (neg_reg || zero_reg)
            bin_calc = '0;
        else if (q_p1 >= (LEN_W + 1)'(NUM_BINS - 1))
            bin_calc = BIN_W'(NUM_BINS - 1);
        else
            bin_calc = q_p1[BIN_W-1:0];
    end

    assign bin_ext   = 32'(bin_calc);
    assign cur_count = rd_valid_reg ? rd_data_reg : '0;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + CNT_W'(1);
    assign do_update = ctl.update & !(out_valid_reg & !m_tready);
    assign mem_we    = do_update & (cmd_reg == CMD_ADD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            bin_size_reg  <= BIN_SIZE_RESET;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_wr_en)
                bin_size_reg <= cfg_wr_data;
            if (ctl.div_init)
                dcnt_reg <= DCNT_W'(DIV_STEPS);
            else if (ctl.div_step)
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            if (mem_we)
                valid_reg[addr_reg] <= 1'b1;
            if (do_update)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= s_tuser;
            first_reg <= s_tdata[COORD_W-1:0];
            last_reg  <= s_tdata[2*COORD_W-1:COORD_W];
            rbin_reg  <= s_tdata[2*COORD_W+RBIN_W-1:2*COORD_W];
        end
        if (ctl.div_init)
        begin
            neg_reg  <= last_p1 < {1'b0, first_reg};
            zero_reg <= last_p1 == {1'b0, first_reg};
            quo_reg  <= length;
            rem_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            quo_reg <= {quo_reg[LEN_W-2:0], qbit};
            rem_reg <= qbit ? BS_W'(rem_sh - {1'b0, bin_size_reg}) : rem_sh[BS_W-1:0];
        end
        if (ctl.set_addr)
        begin
            if (cmd_reg == CMD_READ)
            begin
                addr_reg    <= rbin_ext[BIN_W-1:0];
                touched_reg <= rbin_reg;
                oor_reg     <= rbin_ext >= 32'(NUM_BINS);
            end
            else
            begin
                addr_reg    <= bin_calc;
                touched_reg <= bin_ext[TOUCH_W-1:0];
                oor_reg     <= 1'b0;
            end
        end
        if (ctl.mem_read)
        begin
            rd_data_reg  <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
        end
        if (mem_we)
            mem[addr_reg] <= inc_count;
        if (do_update)
        begin
            out_bin_reg <= touched_reg;
            if (cmd_reg == CMD_READ)
            begin
                out_count_reg <= oor_reg ? '0 : cur_count;
                out_neg_reg   <= 1'b0;
            end
            else
            begin
                out_count_reg <= inc_count;
                out_neg_reg   <= neg_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_bin_reg};
    assign m_tuser  = out_neg_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pc_reg == STEP_SETUP)
        else $error("accepted command did not start the program");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg != STEP_IDLE |-> !s_tready)
        else $error("input ready while a command is in flight");

    a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_ADDR && cmd_reg == CMD_ADD) |-> dcnt_reg == '0)
        else $error("bin chosen before the divider finished");

    a_neg_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (do_update && cmd_reg == CMD_ADD && neg_reg) |-> touched_reg == '0)
        else $error("negative length not counted in bin 0");

endmodule

[sim/lhb_histogram_checker.sv]
// Checker for the length histogram binner: predicts every result and compares it on the master stream.
`timescale 1ns / 1ps

module lhb_histogram_checker
    import lhb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [BS_W-1:0]       cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    mismatches,
    output int                    results_seen,
    output int                    outstanding
);

    typedef struct packed {
        logic [TOUCH_W-1:0] bin;
        logic [CNT_W-1:0]   count;
        logic               negative;
    } bin_result_t;

    logic [CNT_W-1:0] bin_counts [NUM_BINS];
    logic [BS_W-1:0]  bin_size;
    bin_result_t      expected_bins [$];
    int               reports;

    function automatic bin_result_t count_segment(input logic cmd,
                                                  input logic [COORD_W-1:0] first,
                                                  input logic [COORD_W-1:0] last,
                                                  input logic [RBIN_W-1:0] rbin);
        bin_result_t      r;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] q;
        int               idx;
        r.negative = 1'b0;
        if (cmd == CMD_READ)
        begin
            r.bin   = rbin;
            r.count = (int'(rbin) < NUM_BINS) ? bin_counts[rbin] : '0;
            return r;
        end
        if ({1'b0, last} + LEN_W'(1) < {1'b0, first})
        begin
            idx        = 0;
            r.negative = 1'b1;
        end
        else if ({1'b0, last} + LEN_W'(1) == {1'b0, first})
            idx = 0;
        else if (bin_size == '0)
            idx = NUM_BINS - 1;
        else
        begin
            len = {1'b0, last} - {1'b0, first} + LEN_W'(1);
            q   = CNT_W'(len / bin_size) + CNT_W'(1);
            idx = (q >= CNT_W'(NUM_BINS - 1)) ? NUM_BINS - 1 : int'(q);
        end
        if (bin_counts[idx] != COUNT_MAX)
            bin_counts[idx] = bin_counts[idx] + CNT_W'(1);
        r.count = bin_counts[idx];
        r.bin   = TOUCH_W'(idx);
        return r;
    endfunction

    function automatic void report(input string what, input longint want, input longint got);
        mismatches++;
        if (reports < 40)
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        reports++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t got;
        bin_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                bin_counts[i] = '0;
            bin_size = BIN_SIZE_RESET;
            expected_bins.delete();
            mismatches   = 0;
            results_seen = 0;
            reports      = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.bin      = m_tdata[TOUCH_W-1:0];
                got.count    = m_tdata[TOUCH_W +: CNT_W];
                got.negative = m_tuser;
                results_seen++;
                if (expected_bins.size() == 0)
                    report("unexpected result, bin_count", 64'(0), longint'(got.count));
                else
                begin
                    want = expected_bins.pop_front();
                    if (got.bin != want.bin)
                        report("bin_touched", longint'(want.bin), longint'(got.bin));
                    if (got.count != want.count)
                        report("bin_count", longint'(want.count), longint'(got.count));
                    if (got.negative != want.negative)
                        report("negative_length", longint'(want.negative),
                               longint'(got.negative));
                end
            end
            if (cfg_wr_en)
                bin_size = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_bins.push_back(count_segment(s_tuser, s_tdata[COORD_W-1:0],
                                                      s_tdata[COORD_W +: COORD_W],
                                                      s_tdata[2*COORD_W +: RBIN_W]));
        end
        outstanding = expected_bins.size();
    end

endmodule

[sim/tb_length_histogram_binner_unit.sv]
// Testbench top for the length histogram binner: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_length_histogram_binner_unit;
    import lhb_pkg::*;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [BS_W-1:0]       cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int mismatches;
    int results_seen;
    int outstanding;
    int items_sent    = 0;
    int reads_sent    = 0;
    int send_idle_pct = 11;
    int recv_idle_pct = 64;

    length_histogram_binner_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    lhb_histogram_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_cmd(input logic cmd, input logic [COORD_W-1:0] first,
                            input logic [COORD_W-1:0] last, input logic [RBIN_W-1:0] rbin);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rbin, last, first};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (cmd == CMD_READ)
            reads_sent++;
    endtask

    task automatic send_segment(input logic [COORD_W-1:0] first,
                                input logic [COORD_W-1:0] last);
        send_cmd(CMD_ADD, first, last, '0);
    endtask

    task automatic read_count(input logic [RBIN_W-1:0] rbin);
        send_cmd(CMD_READ, COORD_W'($urandom), COORD_W'($urandom), rbin);
    endtask

    task automatic set_bin_size(input logic [BS_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (results_seen == items_sent);
        repeat (40) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_segment(input logic [BS_W-1:0] bs);
        int unsigned kind;
        int unsigned len;
        int unsigned f;
        kind = $urandom_range(99);
        if (kind < 30)
            read_count(RBIN_W'($urandom_range(255)));
        else if (kind < 38)
        begin
            f = $urandom_range(24'hFFFFFF, 2);
            send_segment(COORD_W'(f), COORD_W'($urandom_range(f - 2, 0)));
        end
        else if (kind < 43)
        begin
            f = $urandom_range(24'hFFFFFF, 1);
            send_segment(COORD_W'(f), COORD_W'(f - 1));
        end
        else if (kind < 55)
            send_segment(COORD_W'($urandom), COORD_W'($urandom));
        else
        begin
            if (bs == '0)
                len = $urandom_range(32'h0100_0000, 1);
            else
                len = $urandom_range(256, 0) * bs + $urandom_range(bs - 1, 0);
            if (len == 0 || len > 32'h0100_0000)
                len = $urandom_range(32'h0100_0000, 1);
            f = $urandom_range(32'h0100_0000 - len, 0);
            send_segment(COORD_W'(f), COORD_W'(f + len - 1));
        end
    endtask

    initial
    begin
        logic [BS_W-1:0] sizes [6];
        sizes[0] = 16'd1;
        sizes[1] = 16'hFFFF;
        sizes[2] = 16'd0;
        sizes[3] = BS_W'($urandom_range(2000, 2));
        sizes[4] = BIN_SIZE_RESET;
        sizes[5] = BS_W'($urandom_range(65535, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_count(8'd0);
        read_count(8'd255);
        send_segment(24'd5, 24'd4);
        send_segment(24'hFFFFFF, 24'hFFFFFE);
        send_segment(24'd10, 24'd0);
        send_segment(24'hFFFFFF, 24'd0);
        send_segment(24'd0, 24'd0);
        send_segment(24'hFFFFFF, 24'hFFFFFF);
        send_segment(24'd0, 24'd98);
        send_segment(24'd1000, 24'd1099);
        send_segment(24'd0, 24'd25398);
        send_segment(24'd0, 24'd25399);
        send_segment(24'd0, 24'hFFFFFF);
        send_segment(24'h123456, 24'hFFFFFF);
        send_cmd(CMD_READ, 24'hFFFFFF, 24'hFFFFFF, 8'h01);
        read_count(8'd2);
        read_count(8'd254);
        read_count(8'd255);
        read_count(8'hAA);
        read_count(8'h55);
        read_count(8'd0);

        for (int p = 0; p < 6; p++)
        begin
            set_bin_size(sizes[p]);
            if (p == 2)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 11;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 268; i++)
                random_segment(sizes[p]);
            for (int b = 0; b < 4; b++)
                read_count(b == 3 ? 8'd255 : RBIN_W'($urandom_range(255)));
        end

        s_tvalid <= 1'b0;
        wait (results_seen == items_sent);
        repeat (40) @(posedge clk);
        $display("covered %0d commands (%0d reads) with bin sizes 100, 1, 65535, 0, %0d, 100, %0d",
                 items_sent, reads_sent, sizes[3], sizes[5]);
        $display("light sender and heavy receiver stalls, then the reverse, then no stalls");
        if (mismatches == 0 && outstanding == 0 && results_seen == items_sent)
            $display("tb_length_histogram_binner_unit passed");
        else
            $display("tb_length_histogram_binner_unit failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout after %0d results", results_seen);
        $display("tb_length_histogram_binner_unit failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lhb_pkg.sv
hw/rtl/length_histogram_binner_unit.sv
sim/lhb_histogram_checker.sv
sim/tb_length_histogram_binner_unit.sv
